// ----- sv/mfw_pkg.sv -----
`timescale 1ns / 1ps
// Package for the median filter window block: register indexes, window modes,
// window geometry and the control struct of the rank unit. No dependencies.
package mfw_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int MODE_W  = 2;
  localparam int WIN     = 5;
  localparam int WIN_N   = WIN * WIN;
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;
  localparam int RAD_W   = 2;
  localparam int MIN_DIM = 3;

  // rank of the median among 9 or 25 elements
  localparam int MED_RANK3 = 4;
  localparam int MED_RANK5 = 12;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

  // window modes; the unused code behaves as copy
  localparam logic [MODE_W-1:0] MODE_MED3 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MED5 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COPY = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0]   col_t;
  typedef pix_t [WIN_N-1:0] win_t;

  // load enables of the two rank stages
  typedef struct packed {
    logic load_cmp;
    logic load_sel;
  } med_ctl_t;

endpackage

// ----- sv/mfw_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the median filter window block.
// Depends on mfw_pkg.
interface mfw_pix_in_if;
  logic               valid;
  logic               ready;
  mfw_pkg::pix_t      in_pixel;
  logic               flush;
  modport source (output valid, output in_pixel, output flush, input ready);
  modport sink   (input valid, input in_pixel, input flush, output ready);
endinterface

interface mfw_pix_out_if;
  logic               valid;
  logic               ready;
  mfw_pkg::pix_t      out_pixel;
  logic               last_of_frame;
  modport source (output valid, output out_pixel, output last_of_frame, input ready);
  modport sink   (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

interface mfw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mfw_pkg::IDX_W-1:0]   index;
  logic [mfw_pkg::CFG_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mfw_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read returns the old word on a same-address write. No dependencies.
module mfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mfw_col_cell.sv -----
`timescale 1ns / 1ps
// One column cell of the window: five pixels, loaded from the right-hand
// neighbor on each shift. Depends on mfw_pkg.
module mfw_col_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  mfw_pkg::col_t col_i,
  output mfw_pkg::col_t col_o
);

  mfw_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ----- sv/mfw_median.sv -----
`timescale 1ns / 1ps
// Two-stage rank unit: pairwise compare matrix, then rank count and one-hot
// pick of the median element. Depends on mfw_pkg.
module mfw_median (
  input  logic                           clk_i,
  input  mfw_pkg::med_ctl_t              ctl_i,
  input  logic [mfw_pkg::MODE_W-1:0]     mode_i,
  input  mfw_pkg::win_t                  win_i,
  output mfw_pkg::pix_t                  med_o
);

  localparam int N = mfw_pkg::WIN_N;

  logic [N-1:0]          mask;
  logic [N-1:0][N-1:0]   lt_d, lt_q;
  mfw_pkg::win_t         val3_q, val4_q;
  logic [N-1:0]          sel_d, sel_q;
  logic [4:0]            target;
  mfw_pkg::pix_t         med;

  // 3x3 uses the lower-right corner of the window
  always_comb begin
    for (int e = 0; e < N; e++) begin
      mask[e] = (mode_i == mfw_pkg::MODE_MED5) ||
                ((e / mfw_pkg::WIN >= 2) && (e % mfw_pkg::WIN >= 2));
    end
    target = (mode_i == mfw_pkg::MODE_MED5) ? 5'(mfw_pkg::MED_RANK5)
                                            : 5'(mfw_pkg::MED_RANK3);
  end

  // lt[i][j]: element j orders before element i (ties broken by index)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt_d[i][j] = (i != j) && mask[j] &&
                     ((win_i[j] < win_i[i]) || ((win_i[j] == win_i[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel_d[i] = mask[i] && (5'($countones(lt_q[i])) == target);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_cmp) begin
      lt_q   <= lt_d;
      val3_q <= win_i;
    end
    if (ctl_i.load_sel) begin
      sel_q  <= sel_d;
      val4_q <= val3_q;
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      med = med | (sel_q[i] ? val4_q[i] : '0);
    end
  end

  assign med_o = med;

endmodule

// ----- sv/median_filter_window.sv -----
`timescale 1ns / 1ps
// Streaming 3x3 / 5x5 median filter (or plain copy) over an 8-bit raster frame.
// Depends on mfw_pkg, mfw_if, mfw_ram, mfw_col_cell and mfw_median.
//
//  channel    | dir | fields                  | transfer when
//  -----------+-----+-------------------------+-------------------
//  pix_in_i   | in  | in_pixel, flush         | valid & ready
//  pix_out_o  | out | out_pixel, last_of_frame| valid & ready
//  cfg_i      | in  | index, data             | valid (ready is 1)
//
// One pixel or flush transfer per clock while pix_in_i.ready is high. After
// its input transfer an output passes line store read, window shift, compare
// matrix, rank pick and output register. Every stage holds under stall and a
// stage frees as soon as its successor does, so a stalled result holds the
// input only once all five stage registers are full.
// Reset clears position counters, window and stage valids and loads the
// default configuration; the line stores hold whatever they held.
module median_filter_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mfw_pix_in_if.sink    pix_in_i,
  mfw_pix_out_if.source pix_out_o,
  mfw_cfg_if.sink       cfg_i
);

  localparam int CW = $clog2(MAX_WIDTH);      // column index
  localparam int RW = $clog2(MAX_HEIGHT);     // row index
  localparam int WW = $clog2(MAX_WIDTH + 1);  // width value
  localparam int HW = $clog2(MAX_HEIGHT + 1); // height value
  localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  // ---------------- configuration ----------------
  logic [WW-1:0]               width_q;
  logic [HW-1:0]               height_q;
  logic [mfw_pkg::MODE_W-1:0]  mode_q;
  logic                        cfg_xfer;
  logic [mfw_pkg::RAD_W-1:0]   rad;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid;

  always_comb begin
    unique case (mode_q)
      mfw_pkg::MODE_MED3: rad = 2'd1;
      mfw_pkg::MODE_MED5: rad = 2'd2;
      default:            rad = 2'd0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic free1, free2, free3, free4, free_o;
  logic acc;

  assign free_o = !ov_q || pix_out_o.ready;
  assign free4  = !v4_q || free_o;
  assign free3  = !v3_q || free4;
  assign free2  = !v2_q || free3;
  assign free1  = !v1_q || free2;
  assign pix_in_i.ready = free1;
  assign acc = pix_in_i.valid && free1;

  // ---------------- position tracking at transfer ----------------
  logic [RW-1:0] in_row_q, out_row_q, orow, orow_n;
  logic [CW-1:0] in_col_q, out_col_q, ocol, ocol_n;
  logic          at_origin, fire, femit, emit, interior, last;
  logic          col_end, row_end, ocol_end;

  assign at_origin = (in_row_q == '0) && (in_col_q == '0);
  // a new frame drops whatever was still pending
  assign orow = (!pix_in_i.flush && at_origin) ? '0 : out_row_q;
  assign ocol = (!pix_in_i.flush && at_origin) ? '0 : out_col_q;

  assign fire  = (in_row_q > RW'(rad)) || ((in_row_q == RW'(rad)) && (in_col_q >= CW'(rad)));
  assign femit = at_origin && ((out_row_q != '0) || (out_col_q != '0));
  assign emit  = pix_in_i.flush ? femit : fire;

  assign interior = (rad != '0) &&
                    (orow >= RW'(rad)) &&
                    ((HW+1)'(orow) + (HW+1)'(rad) < (HW+1)'(height_q)) &&
                    (ocol >= CW'(rad)) &&
                    ((WW+1)'(ocol) + (WW+1)'(rad) < (WW+1)'(width_q));

  assign ocol_end = ((WW+1)'(ocol) + (WW+1)'(1) == (WW+1)'(width_q));
  assign last     = ocol_end && ((HW+1)'(orow) + (HW+1)'(1) == (HW+1)'(height_q));
  assign ocol_n   = ocol_end ? '0 : ocol + CW'(1);
  assign orow_n   = last ? '0 : (ocol_end ? orow + RW'(1) : orow);

  assign col_end = ((WW+1)'(in_col_q) + (WW+1)'(1) == (WW+1)'(width_q));
  assign row_end = ((HW+1)'(in_row_q) + (HW+1)'(1) == (HW+1)'(height_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WW'(RST_W);
      height_q  <= HW'(RST_H);
      mode_q    <= mfw_pkg::MODE_MED3;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_xfer && (cfg_i.index == mfw_pkg::REG_WIDTH ||
                              cfg_i.index == mfw_pkg::REG_HEIGHT ||
                              cfg_i.index == mfw_pkg::REG_MODE)) begin
      unique case (cfg_i.index)
        mfw_pkg::REG_WIDTH: begin
          width_q <= (cfg_i.data < mfw_pkg::CFG_W'(mfw_pkg::MIN_DIM)) ? WW'(mfw_pkg::MIN_DIM) :
                     (int'(cfg_i.data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_i.data);
        end
        mfw_pkg::REG_HEIGHT: begin
          height_q <= (cfg_i.data < mfw_pkg::CFG_W'(mfw_pkg::MIN_DIM)) ? HW'(mfw_pkg::MIN_DIM) :
                      (int'(cfg_i.data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_i.data);
        end
        default: begin
          mode_q <= cfg_i.data[mfw_pkg::MODE_W-1:0];
        end
      endcase
      // any register write restarts the frame
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (acc) begin
      if (!pix_in_i.flush) begin
        in_col_q <= col_end ? '0 : in_col_q + CW'(1);
        if (col_end) begin
          in_row_q <= row_end ? '0 : in_row_q + RW'(1);
        end
      end
      if (emit) begin
        out_row_q <= orow_n;
        out_col_q <= ocol_n;
      end else if (!pix_in_i.flush) begin
        out_row_q <= orow;
        out_col_q <= ocol;
      end
    end
  end

  // ---------------- line stores: one RAM per row slot ----------------
  mfw_pkg::pix_t              ram_rd [mfw_pkg::SLOTS];
  logic [mfw_pkg::SLOT_W-1:0] wslot;

  assign wslot = in_row_q[mfw_pkg::SLOT_W-1:0];

  for (genvar s = 0; s < mfw_pkg::SLOTS; s++) begin : g_line
    mfw_ram #(
      .WIDTH (mfw_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (acc && !pix_in_i.flush && (wslot == mfw_pkg::SLOT_W'(s))),
      .waddr_i (in_col_q),
      .wdata_i (pix_in_i.in_pixel),
      .re_i    (acc),
      .raddr_i (pix_in_i.flush ? out_col_q : in_col_q),
      .rdata_o (ram_rd[s])
    );
  end

  // ---------------- stage 1: line store data ----------------
  logic                        flush1_q, emit1_q, int1_q, last1_q;
  mfw_pkg::pix_t               px1_q;
  logic [mfw_pkg::SLOT_W-1:0]  base1_q, fslot1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (free1) begin
      v1_q <= acc && (!pix_in_i.flush || femit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      flush1_q <= pix_in_i.flush;
      emit1_q  <= emit;
      int1_q   <= interior;
      last1_q  <= last;
      px1_q    <= pix_in_i.in_pixel;
      base1_q  <= wslot;
      fslot1_q <= orow[mfw_pkg::SLOT_W-1:0];
    end
  end

  // ---------------- stage 2: window, a chain of column cells ----------------
  mfw_pkg::col_t new_col;
  mfw_pkg::col_t cell_out [mfw_pkg::WIN];
  mfw_pkg::win_t win;
  logic          shift;

  // rows k = 0..3 are the four earlier rows, oldest first
  always_comb begin
    for (int k = 0; k < mfw_pkg::WIN - 1; k++) begin
      new_col[k] = ram_rd[base1_q + mfw_pkg::SLOT_W'(k)];
    end
    new_col[mfw_pkg::WIN-1] = px1_q;
  end

  assign shift = free2 && v1_q && !flush1_q;

  for (genvar j = 0; j < mfw_pkg::WIN; j++) begin : g_cell
    mfw_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .col_i   ((j == mfw_pkg::WIN - 1) ? new_col : cell_out[(j + 1) % mfw_pkg::WIN]),
      .col_o   (cell_out[j])
    );
    for (genvar k = 0; k < mfw_pkg::WIN; k++) begin : g_row
      assign win[k * mfw_pkg::WIN + j] = cell_out[j][k];
    end
  end

  logic          flush2_q, int2_q, last2_q;
  mfw_pkg::pix_t fpass2_q, pass2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (free2) begin
      v2_q <= v1_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free2) begin
      flush2_q <= flush1_q;
      int2_q   <= int1_q;
      last2_q  <= last1_q;
      fpass2_q <= ram_rd[fslot1_q];
    end
  end

  // pass-through pixel sits at the window center lagging by the radius
  always_comb begin
    unique case (rad)
      2'd1:    pass2 = win[18];
      2'd2:    pass2 = win[12];
      default: pass2 = win[24];
    endcase
    if (flush2_q) begin
      pass2 = fpass2_q;
    end
  end

  // ---------------- stages 3 and 4: rank unit ----------------
  mfw_pkg::med_ctl_t med_ctl;
  mfw_pkg::pix_t     med;

  assign med_ctl.load_cmp = free3;
  assign med_ctl.load_sel = free4;

  mfw_median u_median (
    .clk_i  (clk_i),
    .ctl_i  (med_ctl),
    .mode_i (mode_q),
    .win_i  (win),
    .med_o  (med)
  );

  logic          int3_q, last3_q, int4_q, last4_q;
  mfw_pkg::pix_t pass3_q, pass4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free3) begin
      int3_q  <= int2_q;
      last3_q <= last2_q;
      pass3_q <= pass2;
    end
    if (free4) begin
      int4_q  <= int3_q;
      last4_q <= last3_q;
      pass4_q <= pass3_q;
    end
  end

  // ---------------- output register ----------------
  mfw_pkg::pix_t opix_q;
  logic          olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (free_o) begin
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      opix_q  <= int4_q ? med : pass4_q;
      olast_q <= last4_q;
    end
  end

  assign pix_out_o.valid         = ov_q;
  assign pix_out_o.out_pixel     = opix_q;
  assign pix_out_o.last_of_frame = olast_q;

endmodule

// ----- sv/mfw_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the median filter window, bound to the top level.
// Depends on median_filter_window and mfw_pkg.
module mfw_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input mfw_pkg::pix_t out_pixel_i,
  input logic          out_last_i,
  input logic          cfg_ready_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i) && $stable(out_last_i))
    else $error("output changed under stall");

  // an empty output register means every stage can move, so input is ready
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config port not ready");

  // pipeline starts empty after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) && rst_ni |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind median_filter_window mfw_checker u_mfw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_in_i.ready),
  .out_valid_i (pix_out_o.valid),
  .out_ready_i (pix_out_o.ready),
  .out_pixel_i (pix_out_o.out_pixel),
  .out_last_i  (pix_out_o.last_of_frame),
  .cfg_ready_i (cfg_i.ready)
);
